@@ hdl/rmd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_pkg: shared constants and input remap rom
// Register addresses, defaults and the raw-index to sensor mapping.
// ----------------------------------------------------------------------------
package rmd_pkg;

    localparam int SENSOR_COUNT_DEF    = 128;
    localparam int RAW_INPUT_COUNT_DEF = 146;
    localparam int COUNT_WIDTH_DEF     = 16;

    localparam int          RELOAD_W        = 16;
    localparam logic [15:0] RELOAD_AT_RESET = 16'd10;
    localparam logic [7:0]  DIRECT_INPUTS   = 8'd10;
    localparam logic [4:0]  GROUP_COUNT     = 5'd17;

    localparam int          APB_AW       = 3;
    localparam logic [2:0]  ADDR_RELOAD  = 3'd0;

    typedef struct packed {
        logic       hit;
        logic [6:0] id;
    } map_t;

    function automatic logic [3:0] group_size(input logic [4:0] g);
        logic [3:0] s;
        case (g)
            5'd0:    s = 4'd5;
            5'd1:    s = 4'd6;
            5'd2:    s = 4'd7;
            5'd3:    s = 4'd7;
            5'd4:    s = 4'd8;
            5'd5:    s = 4'd7;
            5'd6:    s = 4'd8;
            5'd7:    s = 4'd7;
            5'd8:    s = 4'd8;
            5'd9:    s = 4'd7;
            5'd10:   s = 4'd8;
            5'd11:   s = 4'd7;
            5'd12:   s = 4'd8;
            5'd13:   s = 4'd7;
            5'd14:   s = 4'd7;
            5'd15:   s = 4'd6;
            5'd16:   s = 4'd5;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] group_base(input logic [4:0] g);
        logic [6:0] b;
        case (g)
            5'd0:    b = 7'd10;
            5'd1:    b = 7'd15;
            5'd2:    b = 7'd21;
            5'd3:    b = 7'd28;
            5'd4:    b = 7'd35;
            5'd5:    b = 7'd43;
            5'd6:    b = 7'd50;
            5'd7:    b = 7'd58;
            5'd8:    b = 7'd65;
            5'd9:    b = 7'd73;
            5'd10:   b = 7'd80;
            5'd11:   b = 7'd88;
            5'd12:   b = 7'd95;
            5'd13:   b = 7'd103;
            5'd14:   b = 7'd110;
            5'd15:   b = 7'd117;
            5'd16:   b = 7'd123;
            default: b = 7'd0;
        endcase
        return b;
    endfunction

    // raw index to sensor; the raw input count check stays with the caller
    function automatic map_t map_raw(input logic [7:0] raw);
        map_t       m;
        logic [7:0] off;
        logic [4:0] g;
        logic [2:0] b;
        off = raw - DIRECT_INPUTS;
        g   = off[7:3];
        b   = off[2:0];
        m.hit = 1'b0;
        m.id  = 7'd0;
        if (raw < DIRECT_INPUTS)
        begin
            m.hit = 1'b1;
            m.id  = raw[6:0];
        end
        else if (g < GROUP_COUNT && {1'b0, b} < group_size(g))
        begin
            m.hit = 1'b1;
            m.id  = group_base(g) + {4'd0, b};
        end
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hdl/remapped_multichannel_debouncer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// remapped_multichannel_debouncer_top: remapped counter debouncer
// Maps raw scan samples to sensors and emits one edge event per settled level.
//
// channel   dir   handshake          payload
// s_axis    in    s_tvalid/s_tready  s_tdata: raw_index, level
// m_axis    out   m_tvalid/m_tready  m_tdata: sensor_id; m_tuser: rising
// apb       in    psel/penable       paddr 0: debounce_reload
//
// one sample per clock unless stalled; events pass s1 and the output register
// sensor state in a one-port-write synchronous ram, read at input transfer;
// back-to-back hits on one sensor are forwarded around the ram
// reset clears the level-known flags at once, no clearing pass needed
// input stalls only while an event is ready, the output register is full
// and m_tready is low
// ----------------------------------------------------------------------------
module remapped_multichannel_debouncer_top
    import rmd_pkg::*;
#(
    parameter int SENSOR_COUNT    = SENSOR_COUNT_DEF,
    parameter int RAW_INPUT_COUNT = RAW_INPUT_COUNT_DEF,
    parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [7:0] raw_index, [8] level
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [7:0]        m_tdata,   // [6:0] sensor_id
    output logic                   m_tuser,   // [0] rising
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam int ID_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int WORD_W = COUNT_WIDTH + 1;

    logic [RELOAD_W-1:0]    reload;
    logic [31:0]            reload_ext;
    logic [COUNT_WIDTH-1:0] reload_cut;

    logic [7:0]             in_raw;
    logic                   in_level;
    map_t                   in_map;
    logic [7:0]             in_id8;
    logic                   in_hit;
    logic [ID_W-1:0]        rd_idx;
    logic                   in_xfer;

    logic [WORD_W-1:0]      state_mem [SENSOR_COUNT];
    logic [WORD_W-1:0]      rd_word_reg;
    logic [SENSOR_COUNT-1:0] known_reg;
    logic [SENSOR_COUNT-1:0] known_next;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [6:0]             s1_id_reg;
    logic                   s1_level_reg;
    logic [ID_W-1:0]        s1_idx;
    logic                   fwd_hit_reg;
    logic                   fwd_hit_next;
    logic [WORD_W-1:0]      fwd_word_reg;

    logic [WORD_W-1:0]      cur_word;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] dec_cnt;
    logic                   cur_known;
    logic [WORD_W-1:0]      wr_word;
    logic                   s1_emit;
    logic                   s1_adv;
    logic                   s1_wr;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [6:0]             out_id_reg;
    logic                   out_rising_reg;
    logic                   out_load;

    rmd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .reload  (reload)
    );

    assign reload_ext = {{(32 - RELOAD_W){1'b0}}, reload};
    assign reload_cut = reload_ext[COUNT_WIDTH-1:0];

    // input decode
    assign in_raw   = s_tdata[7:0];
    assign in_level = s_tdata[8];
    assign in_map   = map_raw(in_raw);
    assign in_id8   = {1'b0, in_map.id};
    assign in_hit   = in_map.hit && ({1'b0, in_raw} < 9'(RAW_INPUT_COUNT))
                      && ({1'b0, in_id8} < 9'(SENSOR_COUNT));
    assign rd_idx   = in_id8[ID_W-1:0];
    assign in_xfer  = s_tvalid && s_tready;

    // read-modify-write stage
    assign s1_idx    = ID_W'({1'b0, s1_id_reg});
    assign cur_word  = fwd_hit_reg ? fwd_word_reg : rd_word_reg;
    assign cur_cnt   = cur_word[COUNT_WIDTH-1:0];
    assign dec_cnt   = cur_cnt - COUNT_WIDTH'(1);
    assign cur_known = known_reg[s1_idx];

    always_comb
    begin
        wr_word = cur_word;
        s1_emit = 1'b0;
        if (!cur_known || cur_word[COUNT_WIDTH] != s1_level_reg)
        begin
            wr_word = {s1_level_reg, reload_cut};
        end
        else if (cur_cnt != '0)
        begin
            wr_word = {s1_level_reg, dec_cnt};
            s1_emit = (dec_cnt == '0);
        end
    end

    assign s1_adv   = !s1_emit || !out_valid_reg || m_tready;
    assign s1_wr    = s1_valid_reg && s1_adv;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign out_load = s1_wr && s1_emit;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        fwd_hit_next  = fwd_hit_reg;
        if (in_xfer)
        begin
            s1_valid_next = in_hit;
            fwd_hit_next  = s1_wr && (s1_idx == rd_idx);
        end
        else if (s1_wr)
        begin
            s1_valid_next = 1'b0;
        end

        known_next = known_reg;
        if (s1_wr)
        begin
            known_next[s1_idx] = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rd_word_reg <= state_mem[rd_idx];
        end
        if (s1_wr)
        begin
            state_mem[s1_idx] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_id_reg    <= in_map.id;
            s1_level_reg <= in_level;
            fwd_word_reg <= wr_word;
        end
        if (out_load)
        begin
            out_id_reg     <= s1_id_reg;
            out_rising_reg <= s1_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            known_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            known_reg     <= known_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_id_reg};
    assign m_tuser  = out_rising_reg;

    // checks
    a_emit_from_one: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit) |-> (cur_cnt == COUNT_WIDTH'(1) && cur_known))
        else $error("event without a count of one");

    a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_hit_reg && !s1_valid_reg) |-> !s1_wr)
        else $error("forward hit with empty stage");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> (out_valid_reg && !m_tready && s1_emit))
        else $error("stage stalled without a full output");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_id_reg)))
        else $error("stalled stage lost its item");

endmodule
`default_nettype wire

@@ hdl/rmd_apb_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_apb_regs: configuration register file
// APB slave holding the debounce reload value.
// ----------------------------------------------------------------------------
module rmd_apb_regs
    import rmd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output logic      [RELOAD_W-1:0] reload
);

    logic [RELOAD_W-1:0] reload_reg;
    logic [RELOAD_W-1:0] reload_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_RELOAD);

    always_comb
    begin
        reload_next = reload_reg;
        if (wr_en)
        begin
            reload_next = pwdata[RELOAD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= RELOAD_AT_RESET;
        end
        else
        begin
            reload_reg <= reload_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_RELOAD)
        begin
            prdata = {{(32 - RELOAD_W){1'b0}}, reload_reg};
        end
    end

    assign reload = reload_reg;

endmodule
`default_nettype wire
